/* rtl/core/cmbm_pkg.sv */
// shared types, constants and the row maximum function for the mutual best match core
`default_nettype none
package cmbm_pkg;

	localparam int CNT_W    = 13;
	localparam int MAX_LIVE = 16;
	localparam int CL_W     = 5;
	localparam int POS_W    = 31;
	localparam int OCL_W    = 4;
	localparam int MASK_W   = 16;
	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 24;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef logic [CNT_W-1:0] cnt_t;
	typedef cnt_t [MAX_LIVE-1:0] cnt_vec_t;

	// status from the scan sequencer to the top level
	typedef struct packed {
		logic busy;
		logic rd_en;
		logic clear;
	} scan_stat_t;

	// four level compare tree over one padded row
	function automatic cnt_t max16(input cnt_vec_t v);
		cnt_t l1 [8];
		cnt_t l2 [4];
		cnt_t l3 [2];
		for (int k = 0; k < 8; k++)
			l1[k] = (v[2*k] > v[2*k+1]) ? v[2*k] : v[2*k+1];
		for (int k = 0; k < 4; k++)
			l2[k] = (l1[2*k] > l1[2*k+1]) ? l1[2*k] : l1[2*k+1];
		for (int k = 0; k < 2; k++)
			l3[k] = (l2[2*k] > l2[2*k+1]) ? l2[2*k] : l2[2*k+1];
		return (l3[0] > l3[1]) ? l3[0] : l3[1];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/cluster_mutual_best_match_core.sv */
// top level: read filter, count accumulate with forwarding, count store and scan
// a read's count is written in the cycle after its beat; one read beat per cycle outside a scan
// after the beat marked last: a column max pass over the store, then a read and an output
// beat for each counted row while empty rows are skipped, plus any output stall
// no read beats are taken from the last beat until the scan ends
// reset: asynchronous, clears junction position, row marks and all control; no store sweep
`default_nettype none
module cluster_mutual_best_match_core import cmbm_pkg::*; #(
	parameter int NUM_CLUSTERS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [POS_W-1:0]    cfg_wr_data,   // junction_position
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// right_cluster[4:0], left_cluster[9:5], read_start[40:10], read_end[71:41]
	input  wire logic [S_DATA_W-1:0] s_tdata,
	input  wire logic                s_tlast,       // last_read
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// cluster[3:0], match_mask[19:4], zero[23:20]
	output logic      [M_DATA_W-1:0] m_tdata,
	output logic                     m_tlast        // last_group
);

	localparam int LIVE = (NUM_CLUSTERS < MAX_LIVE) ? NUM_CLUSTERS : MAX_LIVE;
	localparam int RW   = (LIVE > 1) ? $clog2(LIVE) : 1;
	localparam int DW   = LIVE * CNT_W;

	logic [POS_W-1:0]  junction_q;
	logic [LIVE-1:0]   row_seen_q;

	logic [CL_W-1:0]   in_rc;
	logic [CL_W-1:0]   in_lc;
	logic [POS_W-1:0]  in_start;
	logic [POS_W-1:0]  in_end;
	logic              in_hit;
	logic              accept;

	logic              acc_vld_s1;
	logic              acc_hit_s1;
	logic              acc_last_s1;
	logic              acc_seen_s1;
	logic              acc_fwd_s1;
	logic [RW-1:0]     acc_row_s1;
	logic [RW-1:0]     acc_col_s1;
	logic [DW-1:0]     wr_row_q;
	logic [DW-1:0]     base_row;
	logic [DW-1:0]     new_row;

	logic              ram_wr_en;
	logic              ram_rd_en;
	logic [RW-1:0]     ram_rd_addr;
	logic [DW-1:0]     ram_rd_data;

	scan_stat_t        scan_stat;
	logic [RW-1:0]     scan_rd_addr;
	logic              scan_start;
	logic [OCL_W-1:0]  out_cluster;
	logic [MASK_W-1:0] out_mask;

	assign in_rc    = s_tdata[4:0];
	assign in_lc    = s_tdata[9:5];
	assign in_start = s_tdata[40:10];
	assign in_end   = s_tdata[71:41];

	assign in_hit = !in_rc[CL_W-1] && ({1'b0, in_rc[CL_W-2:0]} < CL_W'(LIVE)) &&
	                !in_lc[CL_W-1] && ({1'b0, in_lc[CL_W-2:0]} < CL_W'(LIVE)) &&
	                (in_start <= junction_q) && (in_end >= junction_q);

	assign s_tready   = !scan_stat.busy && !(acc_vld_s1 && acc_last_s1);
	assign accept     = s_tvalid && s_tready;
	assign scan_start = acc_vld_s1 && acc_last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			junction_q <= '0;
		end else if (cfg_wr_en) begin
			junction_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_s1  <= 1'b0;
			acc_hit_s1  <= 1'b0;
			acc_last_s1 <= 1'b0;
			acc_seen_s1 <= 1'b0;
			acc_fwd_s1  <= 1'b0;
		end else begin
			acc_vld_s1  <= accept;
			acc_hit_s1  <= accept && in_hit;
			acc_last_s1 <= accept && s_tlast;
			acc_seen_s1 <= accept && in_hit && row_seen_q[in_rc[RW-1:0]];
			// the row being written now would be read stale
			acc_fwd_s1  <= accept && in_hit && ram_wr_en &&
			               (acc_row_s1 == in_rc[RW-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_row_s1 <= in_rc[RW-1:0];
			acc_col_s1 <= in_lc[RW-1:0];
		end
		if (ram_wr_en) begin
			wr_row_q <= new_row;
		end
	end

	assign ram_wr_en = acc_vld_s1 && acc_hit_s1;

	always_comb begin
		if (acc_fwd_s1) begin
			base_row = wr_row_q;
		end else if (acc_seen_s1) begin
			base_row = ram_rd_data;
		end else begin
			base_row = '0;
		end
		new_row = base_row;
		for (int j = 0; j < LIVE; j++)
			if (acc_col_s1 == RW'(j) && base_row[j*CNT_W +: CNT_W] != CNT_MAX)
				new_row[j*CNT_W +: CNT_W] = base_row[j*CNT_W +: CNT_W] + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_seen_q <= '0;
		end else if (scan_stat.clear) begin
			row_seen_q <= '0;
		end else if (ram_wr_en) begin
			row_seen_q[acc_row_s1] <= 1'b1;
		end
	end

	assign ram_rd_en   = scan_stat.busy ? scan_stat.rd_en : (accept && in_hit);
	assign ram_rd_addr = scan_stat.busy ? scan_rd_addr : in_rc[RW-1:0];

	cmbm_count_ram #(
		.DEPTH (LIVE),
		.AW    (RW),
		.DW    (DW)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (acc_row_s1),
		.wr_data (new_row),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	cmbm_scan #(
		.LIVE (LIVE),
		.RW   (RW),
		.DW   (DW)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (scan_start),
		.row_seen    (row_seen_q),
		.rd_data     (ram_rd_data),
		.out_ready   (m_tready),
		.stat        (scan_stat),
		.rd_addr     (scan_rd_addr),
		.out_valid   (m_tvalid),
		.out_cluster (out_cluster),
		.out_mask    (out_mask),
		.out_last    (m_tlast)
	);

	assign m_tdata = {{(M_DATA_W - MASK_W - OCL_W){1'b0}}, out_mask, out_cluster};

	a_no_beat_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_stat.busy |-> !s_tready)
		else $error("read beat taken during scan");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> !scan_stat.busy)
		else $error("count write overlaps scan");

	a_fwd_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		acc_fwd_s1 |-> $past(ram_wr_en) && acc_hit_s1)
		else $error("forwarding without a preceding write");

endmodule
`default_nettype wire

/* rtl/core/cmbm_count_ram.sv */
// count store: one row of counters per word, one write and one registered read port
`default_nettype none
module cmbm_count_ram import cmbm_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int DW    = 208
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* rtl/core/cmbm_scan.sv */
// column max pass and per-row match emission over the count store
`default_nettype none
module cmbm_scan import cmbm_pkg::*; #(
	parameter int LIVE = 16,
	parameter int RW   = 4,
	parameter int DW   = 208
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [LIVE-1:0]  row_seen,
	input  wire logic [DW-1:0]    rd_data,
	input  wire logic             out_ready,
	output scan_stat_t            stat,
	output logic      [RW-1:0]    rd_addr,
	output logic                  out_valid,
	output logic      [OCL_W-1:0] out_cluster,
	output logic      [MASK_W-1:0] out_mask,
	output logic                  out_last
);

	typedef enum logic [2:0] {
		IDLE,
		COL,
		COL_TAIL,
		EMIT_RD,
		EMIT_OUT
	} state_t;

	state_t            state_q;
	logic   [RW-1:0]   idx_q;
	logic              col_s1;
	cnt_t              colmax_q [LIVE];
	cnt_vec_t          row_vec;
	cnt_t              row_max;
	logic [MASK_W-1:0] mask;
	logic              more_seen;
	logic              at_end;
	logic              slot_free;

	assign at_end    = (idx_q == RW'(LIVE - 1));
	assign slot_free = !out_valid || out_ready;
	assign rd_addr   = idx_q;

	always_comb begin
		stat.busy  = (state_q != IDLE);
		stat.rd_en = ((state_q == COL) || (state_q == EMIT_RD)) && row_seen[idx_q];
		stat.clear = ((state_q == EMIT_RD) && !row_seen[idx_q] && at_end) ||
		             ((state_q == EMIT_OUT) && slot_free && at_end);
	end

	always_comb begin
		row_vec = '0;
		for (int j = 0; j < LIVE; j++)
			row_vec[j] = rd_data[j*CNT_W +: CNT_W];
	end

	assign row_max = max16(row_vec);

	always_comb begin
		mask = '0;
		for (int j = 0; j < LIVE; j++)
			mask[j] = (row_vec[j] != '0) &&
			          ((row_vec[j] == row_max) || (row_vec[j] == colmax_q[j]));
	end

	// any counted row after the current one
	always_comb begin
		more_seen = 1'b0;
		for (int k = 0; k < LIVE; k++)
			if (RW'(k) > idx_q && row_seen[k])
				more_seen = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && start) begin
			for (int j = 0; j < LIVE; j++)
				colmax_q[j] <= '0;
		end else if (col_s1) begin
			for (int j = 0; j < LIVE; j++)
				if (row_vec[j] > colmax_q[j])
					colmax_q[j] <= row_vec[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			idx_q       <= '0;
			col_s1      <= 1'b0;
			out_valid   <= 1'b0;
			out_cluster <= '0;
			out_mask    <= '0;
			out_last    <= 1'b0;
		end else begin
			col_s1 <= (state_q == COL) && row_seen[idx_q];
			if (state_q == EMIT_OUT && slot_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= COL;
						idx_q   <= '0;
					end
				end
				COL: begin
					if (at_end) begin
						state_q <= COL_TAIL;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				COL_TAIL: begin
					state_q <= EMIT_RD;
					idx_q   <= '0;
				end
				EMIT_RD: begin
					if (row_seen[idx_q]) begin
						state_q <= EMIT_OUT;
					end else if (at_end) begin
						state_q <= IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				EMIT_OUT: begin
					if (slot_free) begin
						out_cluster <= OCL_W'(idx_q);
						out_mask    <= mask;
						out_last    <= !more_seen;
						if (at_end) begin
							state_q <= IDLE;
						end else begin
							state_q <= EMIT_RD;
							idx_q   <= idx_q + 1'b1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	// a beat leaves only for a row that was counted
	a_emit_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EMIT_OUT && slot_free) |-> row_seen[idx_q])
		else $error("emitting a row with no counts");

	// the final beat of a set carries last
	a_last_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == EMIT_OUT && slot_free && !more_seen) |=> out_last && out_valid)
		else $error("final row not marked last");

	a_col_data: assert property (@(posedge clk) disable iff (!arst_n)
		col_s1 |-> (state_q == COL || state_q == COL_TAIL))
		else $error("column data outside the column pass");

endmodule
`default_nettype wire

/* tb/tb_cluster_mutual_best_match_core.sv */
// self-checking testbench for the cluster mutual best match core
module tb_cluster_mutual_best_match_core import cmbm_pkg::*;;

	localparam logic [30:0] JMAX       = 31'h7FFFFFFF;
	localparam logic [4:0]  UNASSIGNED = 5'h1F;
	localparam logic [4:0]  MOST_NEG   = 5'h10;
	localparam int          SETTLE     = 80;
	localparam int          LIMIT      = 1000000;
	localparam int          NDIR       = 17;
	localparam int          ITEMS      = 250;

	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} chk_t;
	typedef enum logic [0:0] {ROW_READ, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [4:0]  rc;
		logic [4:0]  lc;
		logic [30:0] rs;
		logic [30:0] re;
		logic        lst;
	} read_t;

	typedef struct packed {
		logic [3:0]  cl;
		logic [15:0] mask;
		logic        lst;
	} grp_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [30:0] val;
		logic [4:0]  rc;
		logic [4:0]  lc;
		logic [30:0] rs;
		logic [30:0] re;
		logic        lst;
		chk_t        chk;
		logic [3:0]  t_cl;
		logic [15:0] t_mask;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [POS_W-1:0]    cfg_wr_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tlast;

	// own copy of the count matrix, row marks and junction
	cnt_t        pair_cnt [16][16];
	logic [15:0] rows_hit;
	logic [30:0] junc;
	grp_t        grp_buf [16];
	grp_t        grp_q [$];

	int errors, groups_seen, groups_due, hits, n_beats, n_sets, n_cfg;
	int burst_left, hold_cnt, rx_phase, cycles;

	dir_row_t dir_tab [NDIR] = '{
		'{ROW_READ, 31'd0, 5'd0, 5'd0, 31'd0, 31'd0, 1'b1, CHK_ONE, 4'd0, 16'h0001},
		'{ROW_READ, 31'd0, UNASSIGNED, 5'd0, 31'd0, 31'd0, 1'b1, CHK_NONE, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, 5'd15, 5'd15, 31'd0, JMAX, 1'b1, CHK_ONE, 4'd15, 16'h8000},
		'{ROW_READ, 31'd0, 5'd5, MOST_NEG, 31'd0, 31'd0, 1'b0, CHK_MODEL, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, MOST_NEG, 5'd5, 31'd0, 31'd0, 1'b1, CHK_NONE, 4'd0, 16'h0},
		'{ROW_CFG, JMAX, 5'd0, 5'd0, 31'd0, 31'd0, 1'b0, CHK_MODEL, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, 5'd7, 5'd9, JMAX, JMAX, 1'b1, CHK_ONE, 4'd7, 16'h0200},
		'{ROW_READ, 31'd0, 5'd7, 5'd9, 31'd0, JMAX - 31'd1, 1'b1, CHK_NONE, 4'd0, 16'h0},
		'{ROW_CFG, 31'd1000, 5'd0, 5'd0, 31'd0, 31'd0, 1'b0, CHK_MODEL, 4'd0, 16'h0},
		// start beyond end
		'{ROW_READ, 31'd0, 5'd2, 5'd2, 31'd1000, 31'd999, 1'b1, CHK_NONE, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, 5'd1, 5'd1, 31'd1001, 31'd2000, 1'b0, CHK_MODEL, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, 5'd1, 5'd1, 31'd0, 31'd999, 1'b0, CHK_MODEL, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, 5'd0, 5'd1, 31'd1000, 31'd1000, 1'b0, CHK_MODEL, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, 5'd0, 5'd2, 31'd0, JMAX, 1'b0, CHK_MODEL, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, 5'd1, 5'd1, 31'd1000, 31'd1000, 1'b0, CHK_MODEL, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, 5'd1, 5'd1, 31'd999, 31'd1001, 1'b0, CHK_MODEL, 4'd0, 16'h0},
		'{ROW_READ, 31'd0, 5'd2, 5'd3, 31'd1000, JMAX, 1'b1, CHK_MODEL, 4'd0, 16'h0}
	};

	cluster_mutual_best_match_core #(.NUM_CLUSTERS(16)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// counts one read and, on the last read of a set, builds the stitch masks
	function automatic int fold_read(input read_t r);
		cnt_t        colmax [16];
		cnt_t        rowmax;
		logic [15:0] mask;
		int          n;
		n = 0;
		if (!r.rc[4] && !r.lc[4] && r.rs <= junc && r.re >= junc) begin
			if (pair_cnt[r.rc[3:0]][r.lc[3:0]] != CNT_MAX)
				pair_cnt[r.rc[3:0]][r.lc[3:0]] = pair_cnt[r.rc[3:0]][r.lc[3:0]] + 1'b1;
			rows_hit[r.rc[3:0]] = 1'b1;
			hits++;
		end
		if (!r.lst)
			return 0;
		for (int j = 0; j < 16; j++) begin
			colmax[j] = '0;
			for (int i = 0; i < 16; i++)
				if (pair_cnt[i][j] > colmax[j])
					colmax[j] = pair_cnt[i][j];
		end
		for (int i = 0; i < 16; i++) begin
			if (rows_hit[i]) begin
				rowmax = '0;
				mask = '0;
				for (int j = 0; j < 16; j++)
					if (pair_cnt[i][j] > rowmax)
						rowmax = pair_cnt[i][j];
				for (int j = 0; j < 16; j++)
					if (pair_cnt[i][j] != 0 &&
					    (pair_cnt[i][j] == rowmax || pair_cnt[i][j] == colmax[j]))
						mask[j] = 1'b1;
				grp_buf[n].cl = i[3:0];
				grp_buf[n].mask = mask;
				grp_buf[n].lst = 1'b0;
				n++;
			end
		end
		if (n > 0)
			grp_buf[n-1].lst = 1'b1;
		for (int i = 0; i < 16; i++)
			for (int j = 0; j < 16; j++)
				pair_cnt[i][j] = '0;
		rows_hit = '0;
		return n;
	endfunction

	// drives one read beat, then maybe a gap before the next burst
	task automatic offer(input read_t r, input chk_t chk, input logic [3:0] t_cl,
	                     input logic [15:0] t_mask);
		grp_t g;
		int   n;
		int   gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {r.re, r.rs, r.lc, r.rc};
		s_tlast  <= r.lst;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_beats++;
		if (r.lst)
			n_sets++;
		n = fold_read(r);
		if (chk == CHK_MODEL) begin
			for (int k = 0; k < n; k++)
				grp_q = {grp_q, grp_buf[k]};
			groups_due += n;
		end else if (chk == CHK_ONE) begin
			g.cl = t_cl;
			g.mask = t_mask;
			g.lst = 1'b1;
			grp_q = {grp_q, g};
			groups_due++;
		end
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 15);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// junction is only rewritten once the block has drained and finished its scan
	task automatic write_junction(input logic [30:0] v);
		s_tvalid <= 1'b0;
		while (grp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		junc = v;
		n_cfg++;
	endtask

	task automatic flag_mismatch(input string what, input logic [31:0] want,
	                             input logic [31:0] got);
		errors++;
		if (errors <= 10)
			$display("mismatch in %s: expected %h, got %h", what, want, got);
	endtask

	// result beat checker
	always @(posedge clk) begin
		grp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			groups_seen++;
			if (grp_q.size() == 0) begin
				flag_mismatch("unexpected group beat", 32'h0, {8'h0, m_tdata});
			end else begin
				want = grp_q.pop_front();
				if (m_tdata[3:0] != want.cl)
					flag_mismatch("cluster", 32'(want.cl), 32'(m_tdata[3:0]));
				if (m_tdata[19:4] != want.mask)
					flag_mismatch("match_mask", 32'(want.mask), 32'(m_tdata[19:4]));
				if (m_tlast != want.lst)
					flag_mismatch("last_group", 32'(want.lst), 32'(m_tlast));
			end
		end
	end

	// receiver: long hold on request, otherwise rotating stall patterns
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cnt > 0) begin
				m_tready <= 1'b0;
				hold_cnt--;
			end else begin
				rx_phase++;
				case ((rx_phase / 64) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_phase % 3 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles, %0d groups outstanding", cycles, grp_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		read_t       r;
		int          k;
		int          n_rd;
		int          rnd_sets;
		int unsigned off;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tlast     <= 1'b0;
		junc = '0;
		rows_hit = '0;
		for (int i = 0; i < 16; i++)
			for (int j = 0; j < 16; j++)
				pair_cnt[i][j] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int t = 0; t < NDIR; t++) begin
			if (dir_tab[t].kind == ROW_CFG) begin
				write_junction(dir_tab[t].val);
			end else begin
				r.rc = dir_tab[t].rc;
				r.lc = dir_tab[t].lc;
				r.rs = dir_tab[t].rs;
				r.re = dir_tab[t].re;
				r.lst = dir_tab[t].lst;
				offer(r, dir_tab[t].chk, dir_tab[t].t_cl, dir_tab[t].t_mask);
			end
		end

		rnd_sets = 0;
		while (n_beats < ITEMS) begin
			if (rnd_sets % 3 == 0) begin
				case ((rnd_sets / 3) % 4)
				0: write_junction(31'd0);
				1: write_junction(JMAX);
				2: write_junction(31'($urandom));
				default: write_junction(31'($urandom_range(1, 5000)));
				endcase
			end
			k = ($urandom_range(0, 3) == 0) ? 16 : $urandom_range(1, 4);
			n_rd = $urandom_range(1, 24);
			if (rnd_sets == 1) begin
				// results back up behind a stalled receiver while the next set waits
				k = 16;
				n_rd = 24;
				hold_cnt = 400;
			end
			for (int i = 0; i < n_rd; i++) begin
				if ($urandom_range(0, 4) == 0) begin
					r.rc = 5'($urandom);
					r.lc = 5'($urandom);
					r.rs = 31'($urandom);
					r.re = 31'($urandom);
				end else begin
					r.rc = 5'($urandom_range(0, k - 1));
					r.lc = 5'($urandom_range(0, k - 1));
					off = $urandom_range(0, 40);
					r.rs = (junc > off) ? 31'(junc - off) : 31'd0;
					off = $urandom_range(0, 40);
					r.re = (JMAX - junc > off) ? 31'(junc + off) : JMAX;
					case ($urandom_range(0, 9))
					0: if (junc != JMAX) r.rs = junc + 1'b1;  // starts just past the junction
					1: if (junc != 0) r.re = junc - 1'b1;     // ends just short of it
					default: ;
					endcase
				end
				r.lst = (i == n_rd - 1);
				offer(r, CHK_MODEL, 4'd0, 16'h0);
			end
			rnd_sets++;
		end

		s_tvalid <= 1'b0;
		while (grp_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("%0d read beats over %0d data sets, %0d counted, %0d junction writes",
		         n_beats, n_sets, hits, n_cfg);
		$display("%0d stitch groups expected, %0d checked, %0d mismatches",
		         groups_due, groups_seen, errors);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
